[design/sro_pkg.sv]
// Shared types and constants for the sequence reorder buffer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package sro_pkg;

  localparam int unsigned SeqW = 32;
  localparam int unsigned TagW = 32;
  localparam int unsigned GapW = 16;
  localparam int unsigned CmdW = 2;
  localparam int unsigned FreeW = 4;

  localparam logic [GapW-1:0] GapReset = 16'd16;
  localparam logic [SeqW-1:0] DistMax = 32'hFFFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_FORCE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // One scanned slot after the distance stage.
  typedef struct packed {
    logic            eq;
    logic [SeqW-1:0] distance;
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
  } entry_t;

  // A candidate picked for return during the scan.
  typedef struct packed {
    logic            found;
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
  } pick_t;

endpackage

`default_nettype wire

[design/sro_dist.sv]
// Distance stage of the slot scan: wrap-aware distance that skips zero.
// Depends on sro_pkg.
`default_nettype none

module sro_dist #(
  parameter int unsigned IdxW = 3
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [IdxW-1:0]         in_idx_i,
  input  wire logic [sro_pkg::SeqW-1:0] seq_i,
  input  wire logic [sro_pkg::TagW-1:0] tag_i,
  input  wire logic [sro_pkg::SeqW-1:0] expect_i,
  output logic                         out_valid_o,
  output logic [IdxW-1:0]              out_idx_o,
  output sro_pkg::entry_t              out_entry_o
);
  import sro_pkg::*;

  logic [SeqW:0]   diff;
  logic [SeqW-1:0] diff_m1;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  entry_t          entry_d, entry_q;

  // A borrow means the number wrapped past zero, which is skipped.
  assign diff    = {1'b0, seq_i} - {1'b0, expect_i};
  assign diff_m1 = seq_i + ~expect_i;

  always_comb begin
    entry_d.eq       = (seq_i == expect_i);
    entry_d.distance = diff[SeqW] ? diff_m1 : diff[SeqW-1:0];
    entry_d.seq      = seq_i;
    entry_d.tag      = tag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= in_idx_i;
    entry_q <= entry_d;
  end

  assign out_valid_o = valid_q;
  assign out_idx_o   = idx_q;
  assign out_entry_o = entry_q;

endmodule

`default_nettype wire

[design/sro_select.sv]
// Eviction test and candidate tracking for the slot scan.
// Depends on sro_pkg.
`default_nettype none

module sro_select #(
  parameter int unsigned IdxW = 3
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic                    in_valid_i,
  input  wire logic [IdxW-1:0]         in_idx_i,
  input  wire sro_pkg::entry_t         in_entry_i,
  input  wire logic                    live_i,
  input  wire logic [sro_pkg::GapW-1:0] gap_i,
  output logic                         evict_o,
  output sro_pkg::pick_t               exact_o,
  output logic [IdxW-1:0]              exact_idx_o,
  output sro_pkg::pick_t               near_o,
  output logic [IdxW-1:0]              near_idx_o
);
  import sro_pkg::*;

  logic            far;
  logic            keep;
  logic [SeqW-1:0] best_q;
  logic            exact_found_q, near_found_q;
  logic [SeqW-1:0] exact_seq_q, near_seq_q;
  logic [TagW-1:0] exact_tag_q, near_tag_q;
  logic [IdxW-1:0] exact_idx_q, near_idx_q;

  assign far     = (in_entry_i.distance >= SeqW'(gap_i));
  assign evict_o = in_valid_i && live_i && far;
  assign keep    = in_valid_i && live_i && !far;

  // The lowest exact match wins; among the rest the later slot wins ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_found_q <= 1'b0;
      near_found_q  <= 1'b0;
    end else if (clear_i) begin
      exact_found_q <= 1'b0;
      near_found_q  <= 1'b0;
    end else begin
      if (keep && in_entry_i.eq && !exact_found_q) begin
        exact_found_q <= 1'b1;
      end
      if (keep && (in_entry_i.distance <= best_q)) begin
        near_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      best_q <= DistMax;
    end else begin
      if (keep && in_entry_i.eq && !exact_found_q) begin
        exact_seq_q <= in_entry_i.seq;
        exact_tag_q <= in_entry_i.tag;
        exact_idx_q <= in_idx_i;
      end
      if (keep && (in_entry_i.distance <= best_q)) begin
        best_q      <= in_entry_i.distance;
        near_seq_q  <= in_entry_i.seq;
        near_tag_q  <= in_entry_i.tag;
        near_idx_q  <= in_idx_i;
      end
    end
  end

  assign exact_o     = '{found: exact_found_q, seq: exact_seq_q, tag: exact_tag_q};
  assign exact_idx_o = exact_idx_q;
  assign near_o      = '{found: near_found_q, seq: near_seq_q, tag: near_tag_q};
  assign near_idx_o  = near_idx_q;

endmodule

`default_nettype wire

[design/sequence_reorder_buffer_top.sv]
// Top level of the sequence reorder buffer: slot memory, valid bits and control.
// Depends on sro_pkg, sro_dist and sro_select.
`default_nettype none

// Usage:
// A command word is taken at a rising edge where start_i is high and busy_o is
// low. Every command first drops stored entries whose distance from
// expected_seq_i is at least the gap limit, then inserts, flushes the exact
// match, force-flushes the exact match or else the nearest entry, or does nothing more.
// Exactly one result word follows each command. It is shown for one cycle with
// res_valid_o high; the receiver cannot stall it.
// busy_o drops in the cycle that shows the result, so the next command can be
// taken on the edge that ends it. The scan reads one slot per cycle from the
// single-port slot memory through a two-stage pipe.
// The gap limit is written with gap_limit_we_i and gap_limit_i; the user must
// do so only while idle, as the block itself does not enforce this.
// Reset empties the store, sets the gap limit to 16 and leaves busy_o low.
// Slot contents are not cleared: only valid slots are ever returned.
module sequence_reorder_buffer_top #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [sro_pkg::CmdW-1:0]  command_i,
  input  wire logic [sro_pkg::SeqW-1:0]  expected_seq_i,
  input  wire logic [sro_pkg::SeqW-1:0]  message_seq_i,
  input  wire logic [sro_pkg::TagW-1:0]  message_tag_i,
  input  wire logic                     gap_limit_we_i,
  input  wire logic [sro_pkg::GapW-1:0]  gap_limit_i,
  output logic                          res_valid_o,
  output logic                          done_res_o,
  output logic [sro_pkg::SeqW-1:0]       out_seq_o,
  output logic [sro_pkg::TagW-1:0]       out_tag_o,
  output logic [sro_pkg::FreeW-1:0]      free_slots_o
);
  import sro_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned MemW = SeqW + TagW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [MemW-1:0] mem [SLOTS];
  logic [MemW-1:0] rdata_q;
  logic            v1_q;
  logic [IdxW-1:0] idx1_q;
  logic [IdxW-1:0] cnt_q;

  logic [SLOTS-1:0] valid_q;
  logic [CntW-1:0]  free_cnt_q, free_cnt_d;
  logic [CntW+FreeW-1:0] free_ext;
  logic [GapW-1:0]  gap_q;

  cmd_e            cmd_q;
  logic [SeqW-1:0] expect_q;
  logic [SeqW-1:0] mseq_q;
  logic [TagW-1:0] mtag_q;

  logic            accept;
  logic            issue;
  logic            v2;
  logic [IdxW-1:0] idx2;
  entry_t          entry2;
  logic            evict;
  pick_t           exact, near;
  logic [IdxW-1:0] exact_idx, near_idx;

  logic            ins_found;
  logic [IdxW-1:0] ins_idx;
  logic            do_insert;
  logic            do_release;
  logic [IdxW-1:0] rel_idx;
  pick_t           chosen;

  logic            res_valid_q;
  logic            done_q;
  logic [SeqW-1:0] oseq_q;
  logic [TagW-1:0] otag_q;
  logic [FreeW-1:0] free_slots_q;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign issue  = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == IdxW'(SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      gap_q   <= GapReset;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (gap_limit_we_i) begin
        gap_q <= gap_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      expect_q <= expected_seq_i;
      mseq_q   <= message_seq_i;
      mtag_q   <= message_tag_i;
    end
  end

  // Slot memory: one read port used by the scan, written when a command ends.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      mem[ins_idx] <= {mtag_q, mseq_q};
    end
    rdata_q <= mem[cnt_q];
    idx1_q  <= cnt_q;
  end

  sro_dist #(
    .IdxW(IdxW)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v1_q),
    .in_idx_i   (idx1_q),
    .seq_i      (rdata_q[SeqW-1:0]),
    .tag_i      (rdata_q[MemW-1:SeqW]),
    .expect_i   (expect_q),
    .out_valid_o(v2),
    .out_idx_o  (idx2),
    .out_entry_o(entry2)
  );

  sro_select #(
    .IdxW(IdxW)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept),
    .in_valid_i (v2),
    .in_idx_i   (idx2),
    .in_entry_i (entry2),
    .live_i     (valid_q[idx2]),
    .gap_i      (gap_q),
    .evict_o    (evict),
    .exact_o    (exact),
    .exact_idx_o(exact_idx),
    .near_o     (near),
    .near_idx_o (near_idx)
  );

  always_comb begin
    ins_found = 1'b0;
    ins_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        ins_found = 1'b1;
        ins_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    do_insert  = 1'b0;
    do_release = 1'b0;
    rel_idx    = exact_idx;
    chosen     = '0;
    if (state_q == ST_DECIDE) begin
      unique case (cmd_q)
        CMD_INSERT: begin
          do_insert = ins_found;
        end
        CMD_FLUSH: begin
          if (exact.found) begin
            do_release = 1'b1;
            chosen     = exact;
          end
        end
        CMD_FORCE: begin
          if (exact.found) begin
            do_release = 1'b1;
            chosen     = exact;
          end else if (near.found) begin
            do_release = 1'b1;
            rel_idx    = near_idx;
            chosen     = near;
          end
        end
        CMD_NONE: begin
          do_release = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    free_cnt_d = free_cnt_q;
    if (evict || do_release) begin
      free_cnt_d = free_cnt_q + CntW'(1);
    end else if (do_insert) begin
      free_cnt_d = free_cnt_q - CntW'(1);
    end
  end

  assign free_ext = (CntW + FreeW)'(free_cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      free_cnt_q <= CntW'(SLOTS);
    end else begin
      free_cnt_q <= free_cnt_d;
      if (evict) begin
        valid_q[idx2] <= 1'b0;
      end else if (do_insert) begin
        valid_q[ins_idx] <= 1'b1;
      end else if (do_release) begin
        valid_q[rel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_DECIDE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      done_q       <= do_insert || do_release;
      oseq_q       <= chosen.seq;
      otag_q       <= chosen.tag;
      free_slots_q <= free_ext[FreeW-1:0];
    end
  end

  assign res_valid_o  = res_valid_q;
  assign done_res_o   = done_q;
  assign out_seq_o    = oseq_q;
  assign out_tag_o    = otag_q;
  assign free_slots_o = free_slots_q;

endmodule

`default_nettype wire

[tb/sro_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the sequence reorder buffer testbench: a predictor of the slot store
// and the queue of result words it expects. Depends on sro_pkg for widths and codes.
package sro_tb_pkg;

  import sro_pkg::*;

  typedef struct {
    logic             done_res;
    logic [SeqW-1:0]  out_seq;
    logic [TagW-1:0]  out_tag;
    logic [FreeW-1:0] free_slots;
  } reorder_result_t;

  class reorder_scoreboard #(int unsigned SLOTS = 8);

    logic [SeqW-1:0] slot_seq_q[SLOTS];
    logic [TagW-1:0] slot_tag_q[SLOTS];
    bit              slot_used_q[SLOTS];
    int unsigned     free_count;
    logic [GapW-1:0] gap_limit;
    reorder_result_t pending_results[$];
    int unsigned     error_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_seq_q[i] = '0;
        slot_tag_q[i] = '0;
        slot_used_q[i] = 1'b0;
      end
      free_count = SLOTS;
      gap_limit = GapReset;
      error_count = 0;
    endfunction

    function void set_gap_limit(logic [GapW-1:0] value);
      gap_limit = value;
    endfunction

    // Distance from the expected number to a stored one; zero is skipped on wrap.
    function logic [SeqW-1:0] seq_gap(logic [SeqW-1:0] from_seq, logic [SeqW-1:0] to_seq);
      logic [SeqW-1:0] d;
      d = to_seq - from_seq;
      if (d > to_seq) d = d - 1'b1;
      return d;
    endfunction

    function void note_command(cmd_e cmd, logic [SeqW-1:0] exp_seq,
                               logic [SeqW-1:0] msg_seq, logic [TagW-1:0] msg_tag);
      reorder_result_t r;
      int unsigned     pick;
      bit              found;
      logic [SeqW-1:0] best;
      logic [SeqW-1:0] d;
      r.done_res = 1'b0;
      r.out_seq = '0;
      r.out_tag = '0;
      found = 1'b0;
      pick = 0;
      best = DistMax;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used_q[i] && seq_gap(exp_seq, slot_seq_q[i]) >= SeqW'(gap_limit)) begin
          slot_used_q[i] = 1'b0;
          free_count++;
        end
      end
      case (cmd)
        CMD_INSERT: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !slot_used_q[i]) begin
              slot_seq_q[i] = msg_seq;
              slot_tag_q[i] = msg_tag;
              slot_used_q[i] = 1'b1;
              free_count--;
              found = 1'b1;
            end
          end
          r.done_res = found;
        end
        CMD_FLUSH, CMD_FORCE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_used_q[i] && slot_seq_q[i] == exp_seq) begin
              found = 1'b1;
              pick = i;
            end
          end
          if (!found && cmd == CMD_FORCE) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_used_q[i]) begin
                d = seq_gap(exp_seq, slot_seq_q[i]);
                if (d <= best) begin
                  best = d;
                  pick = i;
                  found = 1'b1;
                end
              end
            end
          end
          if (found) begin
            r.done_res = 1'b1;
            r.out_seq = slot_seq_q[pick];
            r.out_tag = slot_tag_q[pick];
            slot_used_q[pick] = 1'b0;
            free_count++;
          end
        end
        default: begin
        end
      endcase
      r.free_slots = free_count[FreeW-1:0];
      pending_results.push_back(r);
    endfunction

    function bit pick_stored_seq(output logic [SeqW-1:0] s);
      int unsigned start;
      int unsigned idx;
      start = $urandom_range(0, SLOTS - 1);
      s = '0;
      for (int i = 0; i < SLOTS; i++) begin
        idx = (start + i) % SLOTS;
        if (slot_used_q[idx]) begin
          s = slot_seq_q[idx];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void check_result(logic done_res, logic [SeqW-1:0] out_seq,
                               logic [TagW-1:0] out_tag, logic [FreeW-1:0] free_slots);
      reorder_result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no command waiting");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (done_res !== want.done_res) begin
        $error("done_res: expected %0d, actual %0d", want.done_res, done_res);
        error_count++;
      end
      if (out_seq !== want.out_seq) begin
        $error("out_seq: expected %08h, actual %08h", want.out_seq, out_seq);
        error_count++;
      end
      if (out_tag !== want.out_tag) begin
        $error("out_tag: expected %08h, actual %08h", want.out_tag, out_tag);
        error_count++;
      end
      if (free_slots !== want.free_slots) begin
        $error("free_slots: expected %0d, actual %0d", want.free_slots, free_slots);
        error_count++;
      end
    endfunction

  endclass

endpackage

[tb/sequence_reorder_buffer_top_tb.sv]
`timescale 1ns / 1ps
// Top of the sequence reorder buffer testbench: clock, reset, command driver and monitor.
// Depends on sro_pkg, sro_tb_pkg and the sequence_reorder_buffer_top design.
module sequence_reorder_buffer_top_tb;

  import sro_pkg::*;
  import sro_tb_pkg::*;

  localparam int unsigned Slots = 8;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = Slots + 10;
  localparam int unsigned PhaseWords = 112;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  cmd_e             command_i = CMD_INSERT;
  logic [SeqW-1:0]  expected_seq_i = '0;
  logic [SeqW-1:0]  message_seq_i = '0;
  logic [TagW-1:0]  message_tag_i = '0;
  logic             gap_limit_we_i = 1'b0;
  logic [GapW-1:0]  gap_limit_i = '0;
  logic             busy_o;
  logic             res_valid_o;
  logic             done_res_o;
  logic [SeqW-1:0]  out_seq_o;
  logic [TagW-1:0]  out_tag_o;
  logic [FreeW-1:0] free_slots_o;

  reorder_scoreboard #(Slots) sb;
  int unsigned idle_cycles = 0;

  sequence_reorder_buffer_top #(
    .SLOTS(Slots)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .expected_seq_i(expected_seq_i),
    .message_seq_i (message_seq_i),
    .message_tag_i (message_tag_i),
    .gap_limit_we_i(gap_limit_we_i),
    .gap_limit_i   (gap_limit_i),
    .res_valid_o   (res_valid_o),
    .done_res_o    (done_res_o),
    .out_seq_o     (out_seq_o),
    .out_tag_o     (out_tag_o),
    .free_slots_o  (free_slots_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_result(done_res_o, out_seq_o, out_tag_o, free_slots_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_command(cmd_e cmd, logic [SeqW-1:0] exp_seq,
                              logic [SeqW-1:0] msg_seq, logic [TagW-1:0] msg_tag);
    start_i <= 1'b1;
    command_i <= cmd;
    expected_seq_i <= exp_seq;
    message_seq_i <= msg_seq;
    message_tag_i <= msg_tag;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_command(cmd, exp_seq, msg_seq, msg_tag);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic issue(cmd_e cmd, logic [SeqW-1:0] exp_seq,
                       logic [SeqW-1:0] msg_seq, logic [TagW-1:0] msg_tag);
    send_command(cmd, exp_seq, msg_seq, msg_tag);
    idle_gap(idle_length());
  endtask

  task automatic write_gap_limit(logic [GapW-1:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0 || busy_o) @(posedge clk_i);
    gap_limit_we_i <= 1'b1;
    gap_limit_i <= value;
    @(posedge clk_i);
    gap_limit_we_i <= 1'b0;
    sb.set_gap_limit(value);
  endtask

  task automatic run_directed();
    logic [SeqW-1:0] base;
    logic [TagW-1:0] tag;
    base = 32'hFFFF_FFFC;
    issue(CMD_FORCE, '0, '0, '0);
    issue(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_NONE, '0, '0, '0);
    for (int i = 0; i < Slots; i++) begin
      tag = (i == 0) ? '0 : (i == Slots - 1) ? 32'hFFFF_FFFF : $urandom;
      issue(CMD_INSERT, base, base + i, tag);
    end
    issue(CMD_INSERT, base, 32'd5, $urandom);
    issue(CMD_FLUSH, 32'hFFFF_FFFE, '0, '0);
    issue(CMD_FLUSH, 32'hFFFF_FFFC, '0, '0);
    issue(CMD_FLUSH, 32'hFFFF_FFFD, '0, '0);
    // Numbers FFFFFFFF and 0 are equally near FFFFFFFE because zero is skipped.
    issue(CMD_FORCE, 32'hFFFF_FFFE, '0, '0);
    issue(CMD_FORCE, 32'hFFFF_FFFE, '0, '0);
    issue(CMD_INSERT, '0, '0, 32'hFFFF_FFFF);
    issue(CMD_INSERT, '0, 32'd1, $urandom);
    issue(CMD_FLUSH, 32'd1, '0, '0);
    issue(CMD_NONE, 32'h8000_0000, '0, '0);
    issue(CMD_INSERT, '0, 32'hFFFF_FFFF, $urandom);
    issue(CMD_FORCE, '0, '0, '0);
    issue(CMD_INSERT, 32'h1234_5678, 32'h1234_5678 + 15, $urandom);
    issue(CMD_INSERT, 32'h1234_5678, 32'h1234_5678 + 16, $urandom);
    issue(CMD_NONE, 32'h1234_5678, '0, '0);
  endtask

  task automatic run_phase(logic [GapW-1:0] gap, int unsigned count);
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] exp_seq;
    logic [SeqW-1:0] msg_seq;
    logic [SeqW-1:0] held;
    logic [TagW-1:0] tag;
    cmd_e            cmd;
    int unsigned     span;
    int unsigned     r;
    bit              calm;
    case ($urandom_range(0, 3))
      0: base = 32'hFFFF_FFFF - $urandom_range(0, 40);
      1: base = $urandom_range(0, 40);
      default: base = $urandom;
    endcase
    span = (gap == 0) ? 4 : (gap > 24) ? 24 : gap + 2;
    calm = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        cmd = cmd_e'($urandom_range(0, 3));
        exp_seq = $urandom;
        msg_seq = $urandom;
        tag = $urandom;
      end else begin
        r = $urandom_range(0, 99);
        cmd = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_FLUSH : (r < 95) ? CMD_FORCE : CMD_NONE;
        r = $urandom_range(0, 99);
        if (r < 5) msg_seq = base + gap - 1 + $urandom_range(0, 2);
        else if (r < 10) msg_seq = base - $urandom_range(1, 4);
        else msg_seq = base + $urandom_range(0, span);
        r = $urandom_range(0, 19);
        tag = (r == 0) ? '0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        if (cmd != CMD_INSERT && $urandom_range(0, 9) < 6 && sb.pick_stored_seq(held)) begin
          base = held;
        end
        exp_seq = base;
        if (cmd != CMD_INSERT) base = base + $urandom_range(0, 1);
      end
      send_command(cmd, exp_seq, msg_seq, tag);
      idle_gap(calm ? 0 : idle_length());
    end
  endtask

  initial begin
    logic [GapW-1:0] gap_plan[8];
    gap_plan = '{16'd1, 16'd0, 16'hFFFF, 16'd8, 16'd0, 16'd3, 16'd16, 16'hFFFF};
    gap_plan[4] = GapW'($urandom_range(2, 64));
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      write_gap_limit(gap_plan[p]);
      run_phase(gap_plan[p], PhaseWords);
    end
    start_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
